FILE: hw/rtl/obmss_pkg.sv
package obmss_pkg;

    localparam int AddrW        = 12;
    localparam int ScoreBytes   = 4096;
    localparam int VoiceCount   = 4;
    localparam int PulseCount   = 3;
    localparam int LoopDepth    = 5;
    localparam int ChainLimit   = 256;

    // item kinds
    localparam logic [1:0] KIND_LOAD  = 2'd0;
    localparam logic [1:0] KIND_START = 2'd1;
    localparam logic [1:0] KIND_FRAME = 2'd2;

    // output levels
    localparam logic [7:0] LEVEL_HIGH = 8'd254;
    localparam logic [7:0] LEVEL_LOW  = 8'd127;

    // command classes (high nibble)
    localparam logic [3:0] CMD_REST    = 4'h0;
    localparam logic [3:0] CMD_OCTAVE  = 4'hD;
    localparam logic [3:0] CMD_DUTY    = 4'hE;
    localparam logic [3:0] CMD_CONTROL = 4'hF;

    // control commands (low nibble of an F byte)
    localparam logic [3:0] OP_LOOP     = 4'h0;
    localparam logic [3:0] OP_LOOP_END = 4'h1;
    localparam logic [3:0] OP_MACRO    = 4'h2;
    localparam logic [3:0] OP_TEMPO    = 4'h3;
    localparam logic [3:0] OP_SKIP2_A  = 4'h4;
    localparam logic [3:0] OP_SKIP2_B  = 4'h5;
    localparam logic [3:0] OP_SKIP1_A  = 4'h6;
    localparam logic [3:0] OP_SKIP2_C  = 4'h7;
    localparam logic [3:0] OP_SKIP1_B  = 4'hE;
    localparam logic [3:0] OP_END      = 4'hF;

    typedef struct packed {
        logic [1:0]  kind;
        logic [11:0] address;
        logic [7:0]  data;
    } obmss_in_t;

    typedef struct packed {
        logic [7:0] sample_voice0;
        logic [7:0] sample_voice1;
        logic [7:0] sample_voice2;
        logic [7:0] sample_drum;
    } obmss_out_t;

    // drum sample bits; a byte index past the table reads as zero
    localparam logic [7:0] DRUM_ROM [128] = '{
        8'hAA,8'hB6,8'h87,8'hF8,8'h84,8'h37,8'hE8,8'hC1,
        8'h07,8'h3D,8'hF8,8'hE0,8'h91,8'h87,8'h07,8'h0F,
        8'h0F,8'h1B,8'h1E,
        8'hAA,8'h2A,8'h33,8'h33,8'h33,8'h33,8'h33,8'hCD,
        8'hCC,8'hCC,8'hCC,8'hAC,8'h99,8'h31,8'h33,
        8'h95,8'hB2,8'h00,8'hE3,8'hF0,8'h00,8'hFF,8'h00,
        8'hFE,8'h00,8'h00,8'h00,8'hFF,8'hFF,8'hFF,8'h25,
        8'h00,8'h00,8'h00,8'h00,8'hFF,8'hF7,8'hFF,8'hFF,
        8'hFF,8'hBF,8'h12,8'h00,8'h80,8'h00,8'h00,8'h00,
        8'h00,8'hEE,8'hFF,8'hFF,8'hFF,8'hF7,8'hFF,8'hFE,
        8'h9A,8'h9A,8'hAA,8'h96,8'h74,8'h95,8'h8A,8'hDE,
        8'h74,8'hA0,8'hF7,8'h25,8'h74,8'h68,8'hFF,8'h5B,
        8'h41,8'h80,8'hD4,8'hFD,8'hDE,8'h12,8'h04,8'h24,
        8'hED,8'hFB,8'h5B,8'h25,8'h04,8'h91,8'h6A,8'hDF,
        8'h77,8'h15,8'h02,8'h22,8'hD5,8'h7A,8'hEF,8'hB6,
        8'h24,8'h84,8'hA4,8'hDA,
        8'h9A,8'h74,8'hD4,8'h33,8'h33,8'hE8,8'hE8,8'h55,
        8'h55,8'h00
    };

    function automatic logic [10:0] note_period(input logic [3:0] n);
        logic [10:0] f;
        begin
            case (n)
                4'd1:    f = 11'd1024;
                4'd2:    f = 11'd967;
                4'd3:    f = 11'd912;
                4'd4:    f = 11'd861;
                4'd5:    f = 11'd813;
                4'd6:    f = 11'd767;
                4'd7:    f = 11'd724;
                4'd8:    f = 11'd683;
                4'd9:    f = 11'd645;
                4'd10:   f = 11'd609;
                4'd11:   f = 11'd575;
                4'd12:   f = 11'd542;
                default: f = 11'd255;
            endcase
            return f;
        end
    endfunction

    function automatic logic [7:0] drum_index(input logic [2:0] n);
        logic [7:0] r;
        begin
            case (n)
                3'd0:    r = 8'd0;
                3'd1:    r = 8'd19;
                3'd2:    r = 8'd34;
                3'd3:    r = 8'd74;
                3'd4:    r = 8'd118;
                default: r = 8'd126;
            endcase
            return r;
        end
    endfunction

endpackage

FILE: hw/rtl/one_bit_music_sequencer_synth_unit.sv
// One-bit music sequencer and synthesizer. Load items write one score byte
// each. A start item reads four header words from the score memory. A frame
// item clocks the drum sampler, steps the three pulse voices (each through
// add, wrap and level steps on the shared phase adder) and puts one item of
// four samples into the output register, waiting while that register is
// full; on a tempo tick it then walks the command chain of each voice whose
// note length has run out, where every command is read from score memory
// and macro calls or channel ends also reread a header word (a chain stops
// after 256 commands). The single-port score memory read sets the pace of
// chain interpretation. The sample_divider register resets to 5.
module one_bit_music_sequencer_synth_unit (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  obmss_pkg::obmss_in_t  in_item,
    output logic                  out_valid,
    input  logic                  out_ready,
    output obmss_pkg::obmss_out_t out_item,
    input  logic                  cfg_we,
    input  logic [7:0]            cfg_wdata
);
    import obmss_pkg::*;

    logic        out_valid_reg, out_valid_next;
    obmss_out_t  out_item_reg;
    logic [7:0]  sample_divider_reg;
    logic        emit;
    obmss_out_t  emit_item;

    obmss_core u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd_valid      (in_valid),
        .cmd            (in_item),
        .cmd_ready      (in_ready),
        .sample_divider (sample_divider_reg),
        .out_busy       (out_valid_reg),
        .emit           (emit),
        .emit_item      (emit_item)
    );

    // hold a finished item until taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg      <= 1'b0;
            sample_divider_reg <= 8'd5;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                sample_divider_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_item_reg <= emit_item;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

FILE: hw/rtl/obmss_ram.sv
module obmss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // write one entry when enabled and read the addressed entry, read data registered
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        rdata <= mem_reg[addr];
    end

endmodule

FILE: hw/rtl/obmss_core.sv
module obmss_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_valid,
    input  obmss_pkg::obmss_in_t cmd,
    output logic                 cmd_ready,
    input  logic [7:0]           sample_divider,
    input  logic                 out_busy,
    output logic                 emit,
    output obmss_pkg::obmss_out_t emit_item
);
    import obmss_pkg::*;

    typedef enum logic [11:0] {
        ST_IDLE     = 12'b000000000001,
        ST_PH_ADD   = 12'b000000000010,
        ST_PH_WRAP  = 12'b000000000100,
        ST_PH_LVL   = 12'b000000001000,
        ST_EMIT     = 12'b000000010000,
        ST_TEMPO_V  = 12'b000000100000,
        ST_CH_ISSUE = 12'b000001000000,
        ST_CH_CMD   = 12'b000010000000,
        ST_CH_ARG   = 12'b000100000000,
        ST_HD_HI    = 12'b001000000000,
        ST_HD_LO    = 12'b010000000000,
        ST_HD_DONE  = 12'b100000000000
    } state_t;

    localparam logic [1:0] DRUM_V  = 2'(VoiceCount - 1);
    localparam logic [1:0] LAST_PV = 2'(PulseCount - 1);
    localparam logic [8:0] CHAIN_LAST = 9'(ChainLimit - 1);

    state_t state_reg, state_next;
    logic [1:0]  v_reg, v_next;
    logic [8:0]  n_reg, n_next;
    logic [7:0]  b_reg, b_next;
    logic [15:0] sum_reg, sum_next;
    logic [7:0]  hd_hi_reg, hd_hi_next;
    logic [8:0]  slot_reg, slot_next;
    logic        start_mode_reg, start_mode_next;

    logic [15:0] rp_reg [VoiceCount];
    logic [15:0] rp_next [VoiceCount];
    logic [15:0] ret_reg [VoiceCount];
    logic [15:0] ret_next [VoiceCount];
    logic [6:0]  len_reg [VoiceCount];
    logic [6:0]  len_next [VoiceCount];
    logic [7:0]  oct_reg [VoiceCount];
    logic [7:0]  oct_next [VoiceCount];
    logic [3:0]  dshift_reg [VoiceCount];
    logic [3:0]  dshift_next [VoiceCount];
    logic        lvl_reg [VoiceCount];
    logic        lvl_next [VoiceCount];
    logic [2:0]  lv_reg [VoiceCount];
    logic [2:0]  lv_next [VoiceCount];
    logic [10:0] per_reg [PulseCount];
    logic [10:0] per_next [PulseCount];
    logic [10:0] duty_reg [PulseCount];
    logic [10:0] duty_next [PulseCount];
    logic [15:0] phase_reg [PulseCount];
    logic [15:0] phase_next [PulseCount];

    logic [11:0] tempo_reload_reg, tempo_reload_next;
    logic [11:0] tempo_count_reg, tempo_count_next;
    logic [7:0]  drum_byte_reg, drum_byte_next;
    logic [2:0]  drum_bit_reg, drum_bit_next;
    logic [7:0]  drum_end_reg, drum_end_next;
    logic [7:0]  div_reg, div_next;

    logic [15:0] loop_start_reg [LoopDepth][VoiceCount];
    logic [15:0] loop_rem_reg [LoopDepth][VoiceCount];
    logic        ls_we, lr_we;
    logic [2:0]  lw_idx;
    logic [15:0] ls_wdata, lr_wdata;

    logic             mem_we;
    logic [AddrW-1:0] mem_addr;
    logic [7:0]       mem_rdata;

    // shared-unit operands
    logic [15:0] p;
    logic [1:0]  pv;
    logic        is_pulse;
    logic [7:0]  cb, ca;
    logic [3:0]  hi, lo;
    logic        needs_arg;
    logic        exec_en;
    logic        chain_step, adv_voice;
    logic [2:0]  lv_cur, lv_dec;
    logic [15:0] rem_rd, start_rd;
    logic [10:0] f_val;
    logic [7:0]  rom_byte;
    logic [9:0]  slot_addr;

    obmss_ram #(.WIDTH(8), .DEPTH(ScoreBytes)) u_score (
        .clk   (clk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (cmd.data),
        .rdata (mem_rdata)
    );

    assign p         = rp_reg[v_reg];
    assign pv        = (v_reg > LAST_PV) ? LAST_PV : v_reg;
    assign is_pulse  = (v_reg != DRUM_V);
    assign cb        = (state_reg == ST_CH_ARG) ? b_reg : mem_rdata;
    assign ca        = mem_rdata;
    assign hi        = cb[7:4];
    assign lo        = cb[3:0];
    assign needs_arg = (hi == CMD_CONTROL) &&
                       ((lo == OP_LOOP) || (lo == OP_MACRO) || (lo == OP_TEMPO));
    assign lv_cur    = lv_reg[v_reg];
    assign lv_dec    = lv_cur - 3'd1;
    assign rem_rd    = loop_rem_reg[lv_dec][v_reg];
    assign start_rd  = loop_start_reg[lv_dec][v_reg];
    assign f_val     = note_period(hi);
    assign rom_byte  = drum_byte_reg[7] ? 8'd0 : DRUM_ROM[drum_byte_reg[6:0]];
    assign cmd_ready = (state_reg == ST_IDLE);

    assign emit_item.sample_voice0 = lvl_reg[0] ? LEVEL_HIGH : LEVEL_LOW;
    assign emit_item.sample_voice1 = lvl_reg[1] ? LEVEL_HIGH : LEVEL_LOW;
    assign emit_item.sample_voice2 = lvl_reg[2] ? LEVEL_HIGH : LEVEL_LOW;
    assign emit_item.sample_drum   = lvl_reg[DRUM_V] ? LEVEL_HIGH : LEVEL_LOW;

    // sequencer: one frame/tempo/bytecode step per unstalled cycle
    always_comb
    begin
        state_next        = state_reg;
        v_next            = v_reg;
        n_next            = n_reg;
        b_next            = b_reg;
        sum_next          = sum_reg;
        hd_hi_next        = hd_hi_reg;
        slot_next         = slot_reg;
        start_mode_next   = start_mode_reg;
        rp_next           = rp_reg;
        ret_next          = ret_reg;
        len_next          = len_reg;
        oct_next          = oct_reg;
        dshift_next       = dshift_reg;
        lvl_next          = lvl_reg;
        lv_next           = lv_reg;
        per_next          = per_reg;
        duty_next         = duty_reg;
        phase_next        = phase_reg;
        tempo_reload_next = tempo_reload_reg;
        tempo_count_next  = tempo_count_reg;
        drum_byte_next    = drum_byte_reg;
        drum_bit_next     = drum_bit_reg;
        drum_end_next     = drum_end_reg;
        div_next          = div_reg;
        ls_we             = 1'b0;
        lr_we             = 1'b0;
        lw_idx            = lv_cur;
        ls_wdata          = 16'(p + 16'd2);
        lr_wdata          = 16'({8'd0, ca} - 16'd1);
        mem_we            = 1'b0;
        mem_addr          = p[AddrW-1:0];
        emit              = 1'b0;
        exec_en           = 1'b0;
        chain_step        = 1'b0;
        adv_voice         = 1'b0;
        slot_addr         = {slot_reg, 1'b0};

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    case (cmd.kind)
                        KIND_LOAD:
                        begin
                            mem_we   = 1'b1;
                            mem_addr = cmd.address;
                        end
                        KIND_START:
                        begin
                            for (int i = 0; i < VoiceCount; i++)
                            begin
                                rp_next[i]     = 16'd0;
                                ret_next[i]    = 16'd0;
                                len_next[i]    = 7'd0;
                                oct_next[i]    = 8'd3;
                                dshift_next[i] = 4'd1;
                                lvl_next[i]    = 1'b0;
                                lv_next[i]     = 3'd0;
                            end
                            for (int i = 0; i < PulseCount; i++)
                            begin
                                per_next[i]   = 11'd255;
                                duty_next[i]  = 11'd0;
                                phase_next[i] = 16'd0;
                            end
                            tempo_reload_next = 12'd0;
                            tempo_count_next  = 12'd0;
                            drum_byte_next    = 8'd0;
                            drum_bit_next     = 3'd0;
                            drum_end_next     = 8'd0;
                            div_next          = 8'd0;
                            v_next            = 2'd0;
                            slot_next         = 9'd0;
                            start_mode_next   = 1'b1;
                            state_next        = ST_HD_HI;
                        end
                        KIND_FRAME:
                        begin
                            // clock the drum sampler
                            if (div_reg == 8'd0)
                            begin
                                if (({1'b0, drum_byte_reg} + 9'd1) < {1'b0, drum_end_reg})
                                begin
                                    lvl_next[DRUM_V] = rom_byte[drum_bit_reg];
                                    drum_bit_next    = drum_bit_reg + 3'd1;
                                    if (drum_bit_reg == 3'd7)
                                    begin
                                        drum_byte_next = drum_byte_reg + 8'd1;
                                    end
                                end
                                else
                                begin
                                    lvl_next[DRUM_V] = 1'b0;
                                end
                                div_next = sample_divider;
                            end
                            else
                            begin
                                div_next = div_reg - 8'd1;
                            end
                            v_next     = 2'd0;
                            state_next = ST_PH_ADD;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_PH_ADD:
            begin
                sum_next   = 16'(phase_reg[pv] + {8'd0, oct_reg[v_reg]});
                state_next = ST_PH_WRAP;
            end

            ST_PH_WRAP:
            begin
                if (sum_reg >= {5'd0, per_reg[pv]})
                begin
                    phase_next[pv] = 16'(sum_reg - {5'd0, per_reg[pv]});
                end
                else
                begin
                    phase_next[pv] = sum_reg;
                end
                state_next = ST_PH_LVL;
            end

            ST_PH_LVL:
            begin
                lvl_next[v_reg] = (phase_reg[pv] < {5'd0, duty_reg[pv]});
                if (v_reg == LAST_PV)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    v_next     = v_reg + 2'd1;
                    state_next = ST_PH_ADD;
                end
            end

            ST_EMIT:
            begin
                if (!out_busy)
                begin
                    emit = 1'b1;
                    if (tempo_count_reg == 12'd0)
                    begin
                        tempo_count_next = tempo_reload_reg;
                        v_next           = 2'd0;
                        state_next       = ST_TEMPO_V;
                    end
                    else
                    begin
                        tempo_count_next = tempo_count_reg - 12'd1;
                        state_next       = ST_IDLE;
                    end
                end
            end

            ST_TEMPO_V:
            begin
                if (len_reg[v_reg] == 7'd0)
                begin
                    n_next     = 9'd0;
                    state_next = ST_CH_ISSUE;
                end
                else
                begin
                    len_next[v_reg] = len_reg[v_reg] - 7'd1;
                    adv_voice       = 1'b1;
                end
            end

            ST_CH_ISSUE:
            begin
                state_next = ST_CH_CMD;
            end

            ST_CH_CMD:
            begin
                mem_addr = 12'(p + 16'd1);
                if (needs_arg)
                begin
                    b_next     = mem_rdata;
                    state_next = ST_CH_ARG;
                end
                else
                begin
                    exec_en = 1'b1;
                end
            end

            ST_CH_ARG:
            begin
                exec_en = 1'b1;
            end

            ST_HD_HI:
            begin
                mem_addr   = {2'd0, slot_addr};
                state_next = ST_HD_LO;
            end

            ST_HD_LO:
            begin
                slot_addr  = {slot_reg, 1'b1};
                mem_addr   = {2'd0, slot_addr};
                hd_hi_next = mem_rdata;
                state_next = ST_HD_DONE;
            end

            ST_HD_DONE:
            begin
                rp_next[v_reg] = {hd_hi_reg, mem_rdata};
                if (start_mode_reg)
                begin
                    if (v_reg == DRUM_V)
                    begin
                        start_mode_next = 1'b0;
                        state_next      = ST_IDLE;
                    end
                    else
                    begin
                        v_next     = v_reg + 2'd1;
                        slot_next  = {7'd0, v_reg + 2'd1};
                        state_next = ST_HD_HI;
                    end
                end
                else
                begin
                    chain_step = 1'b1;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // interpret one command byte
        if (exec_en)
        begin
            if (hi == CMD_CONTROL)
            begin
                case (lo)
                    OP_LOOP:
                    begin
                        if (lv_cur < 3'(LoopDepth))
                        begin
                            ls_we         = 1'b1;
                            lr_we         = 1'b1;
                            lv_next[v_reg] = lv_cur + 3'd1;
                        end
                        rp_next[v_reg] = 16'(p + 16'd2);
                        chain_step     = 1'b1;
                    end
                    OP_LOOP_END:
                    begin
                        if ((lv_cur == 3'd0) || (lv_cur > 3'(LoopDepth)))
                        begin
                            rp_next[v_reg] = 16'(p + 16'd1);
                        end
                        else if (rem_rd != 16'd0)
                        begin
                            rp_next[v_reg] = start_rd;
                            lw_idx         = lv_dec;
                            lr_we          = 1'b1;
                            lr_wdata       = rem_rd - 16'd1;
                        end
                        else
                        begin
                            lv_next[v_reg] = lv_dec;
                            rp_next[v_reg] = 16'(p + 16'd1);
                        end
                        chain_step = 1'b1;
                    end
                    OP_MACRO:
                    begin
                        ret_next[v_reg] = 16'(p + 16'd2);
                        slot_next       = 9'({1'b0, ca} + 9'(VoiceCount));
                        start_mode_next = 1'b0;
                        state_next      = ST_HD_HI;
                    end
                    OP_TEMPO:
                    begin
                        tempo_reload_next = {ca, 4'd0};
                        rp_next[v_reg]    = 16'(p + 16'd2);
                        chain_step        = 1'b1;
                    end
                    OP_SKIP2_A, OP_SKIP2_B, OP_SKIP2_C:
                    begin
                        rp_next[v_reg] = 16'(p + 16'd2);
                        chain_step     = 1'b1;
                    end
                    OP_SKIP1_A, OP_SKIP1_B:
                    begin
                        rp_next[v_reg] = 16'(p + 16'd1);
                        chain_step     = 1'b1;
                    end
                    OP_END:
                    begin
                        if (ret_reg[v_reg] != 16'd0)
                        begin
                            rp_next[v_reg]  = ret_reg[v_reg];
                            ret_next[v_reg] = 16'd0;
                            chain_step      = 1'b1;
                        end
                        else
                        begin
                            slot_next       = {7'd0, v_reg};
                            start_mode_next = 1'b0;
                            state_next      = ST_HD_HI;
                        end
                    end
                    default:
                    begin
                        // undefined command: hold the pointer
                        chain_step = 1'b1;
                    end
                endcase
            end
            else if (hi == CMD_OCTAVE)
            begin
                oct_next[v_reg] = lo[3] ? 8'd0 : (8'd1 << lo[2:0]);
                rp_next[v_reg]  = 16'(p + 16'd1);
                chain_step      = 1'b1;
            end
            else if (hi == CMD_DUTY)
            begin
                dshift_next[v_reg] = lo;
                rp_next[v_reg]     = 16'(p + 16'd1);
                chain_step         = 1'b1;
            end
            else
            begin
                // note or rest ends the chain
                if (hi != CMD_REST)
                begin
                    if (is_pulse)
                    begin
                        per_next[pv]  = f_val;
                        duty_next[pv] = 11'((f_val >> dshift_reg[v_reg]) + 11'd1);
                    end
                    else if (hi <= 4'd5)
                    begin
                        drum_bit_next  = 3'd0;
                        drum_byte_next = drum_index(3'(hi - 4'd1));
                        drum_end_next  = drum_index(hi[2:0]);
                    end
                end
                else if (is_pulse)
                begin
                    duty_next[pv] = 11'd0;
                end
                if (!lo[3])
                begin
                    len_next[v_reg] = 7'(8'd127 >> lo[2:0]);
                end
                else
                begin
                    len_next[v_reg] = 7'(8'd95 >> lo[2:0]);
                end
                rp_next[v_reg] = 16'(p + 16'd1);
                adv_voice      = 1'b1;
            end
        end

        // count commands; drop the voice for this tick at the cap
        if (chain_step)
        begin
            if (n_reg == CHAIN_LAST)
            begin
                adv_voice = 1'b1;
            end
            else
            begin
                n_next     = n_reg + 9'd1;
                state_next = ST_CH_ISSUE;
            end
        end

        // advance to the next voice of the tick
        if (adv_voice)
        begin
            if (v_reg == DRUM_V)
            begin
                state_next = ST_IDLE;
            end
            else
            begin
                v_next     = v_reg + 2'd1;
                state_next = ST_TEMPO_V;
            end
        end
    end

    // control and voice state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            v_reg            <= 2'd0;
            n_reg            <= 9'd0;
            start_mode_reg   <= 1'b0;
            slot_reg         <= 9'd0;
            for (int i = 0; i < VoiceCount; i++)
            begin
                rp_reg[i]     <= 16'd0;
                ret_reg[i]    <= 16'd0;
                len_reg[i]    <= 7'd0;
                oct_reg[i]    <= 8'd3;
                dshift_reg[i] <= 4'd1;
                lvl_reg[i]    <= 1'b0;
                lv_reg[i]     <= 3'd0;
            end
            for (int i = 0; i < PulseCount; i++)
            begin
                per_reg[i]   <= 11'd255;
                duty_reg[i]  <= 11'd0;
                phase_reg[i] <= 16'd0;
            end
            tempo_reload_reg <= 12'd0;
            tempo_count_reg  <= 12'd0;
            drum_byte_reg    <= 8'd0;
            drum_bit_reg     <= 3'd0;
            drum_end_reg     <= 8'd0;
            div_reg          <= 8'd0;
        end
        else
        begin
            state_reg        <= state_next;
            v_reg            <= v_next;
            n_reg            <= n_next;
            start_mode_reg   <= start_mode_next;
            slot_reg         <= slot_next;
            rp_reg           <= rp_next;
            ret_reg          <= ret_next;
            len_reg          <= len_next;
            oct_reg          <= oct_next;
            dshift_reg       <= dshift_next;
            lvl_reg          <= lvl_next;
            lv_reg           <= lv_next;
            per_reg          <= per_next;
            duty_reg         <= duty_next;
            phase_reg        <= phase_next;
            tempo_reload_reg <= tempo_reload_next;
            tempo_count_reg  <= tempo_count_next;
            drum_byte_reg    <= drum_byte_next;
            drum_bit_reg     <= drum_bit_next;
            drum_end_reg     <= drum_end_next;
            div_reg          <= div_next;
        end
    end

    // scratch registers
    always_ff @(posedge clk)
    begin
        b_reg     <= b_next;
        sum_reg   <= sum_next;
        hd_hi_reg <= hd_hi_next;
    end

    // loop stack entries
    always_ff @(posedge clk)
    begin
        if (ls_we)
        begin
            loop_start_reg[lw_idx][v_reg] <= ls_wdata;
        end
        if (lr_we)
        begin
            loop_rem_reg[lw_idx][v_reg] <= lr_wdata;
        end
    end

endmodule

FILE: hw/rtl/obmss_chk.sv
module obmss_chk (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_ready,
    input obmss_pkg::obmss_in_t  in_item,
    input logic                  out_valid,
    input logic                  out_ready,
    input obmss_pkg::obmss_out_t out_item
);
    import obmss_pkg::*;

    // stalled item holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_item))
        else $error("output item changed while stalled");

    // samples are only the two levels
    a_levels: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |->
            (out_item.sample_voice0 == LEVEL_HIGH || out_item.sample_voice0 == LEVEL_LOW) &&
            (out_item.sample_voice1 == LEVEL_HIGH || out_item.sample_voice1 == LEVEL_LOW) &&
            (out_item.sample_voice2 == LEVEL_HIGH || out_item.sample_voice2 == LEVEL_LOW) &&
            (out_item.sample_drum == LEVEL_HIGH || out_item.sample_drum == LEVEL_LOW))
        else $error("sample level out of set");

    // a frame item keeps the block busy
    a_frame_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_item.kind == KIND_FRAME |=> !in_ready)
        else $error("ready right after a frame item");

    // a start item produces no result in the next cycle
    a_start_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_item.kind == KIND_START && !out_valid |=> !out_valid)
        else $error("result after a start item");

endmodule

bind one_bit_music_sequencer_synth_unit obmss_chk u_chk (.*);
